### sv/kvd_pkg.sv
// Package for the keyed-alphabet plus Vigenere decipher block.
// Holds sizes, opcodes, register indexes, state codes and the letter decoder.
// Used by kvd_if and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package kvd_pkg;

  localparam int unsigned ALPHA     = 26;
  localparam int unsigned LETTER_W  = 5;
  localparam int unsigned MAX_KEY   = 12;
  localparam int unsigned KPOS_W    = 4;
  localparam int unsigned KEY_W     = MAX_KEY * LETTER_W;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = KEY_W;

  localparam logic [LETTER_W-1:0] ALPHA_C = LETTER_W'(ALPHA);
  localparam logic [6:0]          ASCII_A = 7'h41;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_KEYWORD = 2'd1,
    OP_FINISH  = 2'd2,
    OP_CIPHER  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LENGTH   = 1'b0,
    CFG_VIGENERE_KEY = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FINISH,
    ST_READ
  } state_e;

  typedef struct packed {
    logic                hit;
    logic [LETTER_W-1:0] idx;
  } letter_t;

  // Case-folded letter index; hit is low for anything but A..Z / a..z.
  function automatic letter_t letter_of(input logic [7:0] b);
    letter_t r;
    r.hit = 1'b0;
    r.idx = '0;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r.hit = 1'b1;
      r.idx = LETTER_W'(b - 8'h41);
    end else if (b >= 8'h61 && b <= 8'h7A) begin
      r.hit = 1'b1;
      r.idx = LETTER_W'(b - 8'h61);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/kvd_if.sv
// Valid/ready channel interfaces for the decipher block.
// Uses kvd_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface kvd_in_if;
  logic       valid;
  logic       ready;
  kvd_pkg::op_e opcode;
  logic [7:0] char_byte;

  modport source (output valid, output opcode, output char_byte, input ready);
  modport sink   (input valid, input opcode, input char_byte, output ready);
endinterface

interface kvd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] plain_letter;
  logic [kvd_pkg::KPOS_W-1:0] key_index_used;

  modport source (output valid, output plain_letter, output key_index_used, input ready);
  modport sink   (input valid, input plain_letter, input key_index_used, output ready);
endinterface

`default_nettype wire

### sv/kvd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read data holds until the next read. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module kvd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire                     clk_i,
  input  wire                     wr_en_i,
  input  wire [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire [WIDTH-1:0]         wr_data_i,
  input  wire                     rd_en_i,
  input  wire [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]        rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### sv/keyword_vigenere_decipher_top.sv
// Keyed-alphabet substitution then Vigenere decipher, top level.
// Ciphertext letter: accept and alphabet RAM read, then the read state fills the output register.
// Keyword letter and clear act on acceptance. Finish walks all 26 letters, one letter per cycle.
// One item in flight; the input is ready only in the idle state.
// Reset (async, active low): alphabet empty, key position 0, key length 1, key 0.
// Depends on kvd_pkg, kvd_if and kvd_ram.
`timescale 1ns / 1ps
`default_nettype none

module keyword_vigenere_decipher_top (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire [kvd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire [kvd_pkg::CFG_W-1:0]          cfg_data_i,
  kvd_in_if.sink                            in_i,
  kvd_out_if.source                         out_o
);

  localparam int unsigned LW = kvd_pkg::LETTER_W;
  localparam int unsigned KW = kvd_pkg::KPOS_W;

  kvd_pkg::state_e state_q, state_d;

  logic [kvd_pkg::ALPHA-1:0] used_q, used_d;
  logic [LW-1:0]             fill_q, fill_d;
  logic [KW-1:0]             kpos_q, kpos_d;
  logic [LW-1:0]             walk_q, walk_d;
  logic [KW-1:0]             klen_q;
  logic [kvd_pkg::KEY_W-1:0] key_q;

  logic          out_valid_q, out_valid_d;
  logic [6:0]    out_letter_q, out_letter_d;
  logic [KW-1:0] out_kidx_q, out_kidx_d;

  logic          in_xfer, out_xfer;
  kvd_pkg::letter_t in_let;

  logic          ram_we, ram_re;
  logic [LW-1:0] ram_waddr, ram_wdata, ram_rdata;

  logic [LW-1:0] key_arr [kvd_pkg::MAX_KEY];
  logic [KW-1:0] len_eff, pos_eff, pos_inc;
  logic [LW-1:0] kraw, kmod;
  logic [LW:0]   pdiff;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;
  assign in_let   = kvd_pkg::letter_of(in_i.char_byte);

  assign in_i.ready           = (state_q == kvd_pkg::ST_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.plain_letter   = out_letter_q;
  assign out_o.key_index_used = out_kidx_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= KW'(1);
      key_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kvd_pkg::CFG_KEY_LENGTH:   klen_q <= cfg_data_i[KW-1:0];
        kvd_pkg::CFG_VIGENERE_KEY: key_q  <= cfg_data_i[kvd_pkg::KEY_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < kvd_pkg::MAX_KEY; g++) begin : g_key
    assign key_arr[g] = key_q[g*LW +: LW];
  end

  // Key position arithmetic and the Vigenere subtraction modulo 26
  always_comb begin
    if (klen_q == '0) begin
      len_eff = KW'(1);
    end else if (klen_q > KW'(kvd_pkg::MAX_KEY)) begin
      len_eff = KW'(kvd_pkg::MAX_KEY);
    end else begin
      len_eff = klen_q;
    end
    pos_eff = (kpos_q >= len_eff) ? '0 : kpos_q;
    pos_inc = (pos_eff + KW'(1) >= len_eff) ? '0 : pos_eff + KW'(1);
    kraw    = key_arr[pos_eff];
    kmod    = (kraw >= kvd_pkg::ALPHA_C) ? kraw - kvd_pkg::ALPHA_C : kraw;
    if (ram_rdata >= kmod) begin
      pdiff = {1'b0, ram_rdata} - {1'b0, kmod};
    end else begin
      pdiff = {1'b0, ram_rdata} + (LW+1)'(kvd_pkg::ALPHA) - {1'b0, kmod};
    end
  end

  kvd_ram #(
    .WIDTH (LW),
    .DEPTH (kvd_pkg::ALPHA)
  ) u_alpha_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (in_let.idx),
    .rd_data_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    fill_d       = fill_q;
    kpos_d       = kpos_q;
    walk_d       = walk_q;
    out_valid_d  = out_valid_q;
    out_letter_d = out_letter_q;
    out_kidx_d   = out_kidx_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = in_let.idx;
    ram_wdata    = fill_q;

    if (out_xfer) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      kvd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (in_i.opcode)
            kvd_pkg::OP_CLEAR: begin
              used_d = '0;
              fill_d = '0;
              kpos_d = '0;
            end
            kvd_pkg::OP_KEYWORD: begin
              if (in_let.hit && !used_q[in_let.idx] && fill_q < kvd_pkg::ALPHA_C) begin
                ram_we             = 1'b1;
                used_d[in_let.idx] = 1'b1;
                fill_d             = fill_q + LW'(1);
              end
            end
            kvd_pkg::OP_FINISH: begin
              walk_d  = '0;
              state_d = kvd_pkg::ST_FINISH;
            end
            kvd_pkg::OP_CIPHER: begin
              // unplaced letters and non-letters are taken with no result and keep the key position
              if (in_let.hit && used_q[in_let.idx]) begin
                ram_re  = 1'b1;
                state_d = kvd_pkg::ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      kvd_pkg::ST_FINISH: begin
        ram_waddr = walk_q;
        if (!used_q[walk_q] && fill_q < kvd_pkg::ALPHA_C) begin
          ram_we         = 1'b1;
          used_d[walk_q] = 1'b1;
          fill_d         = fill_q + LW'(1);
        end
        walk_d = walk_q + LW'(1);
        if (walk_q == kvd_pkg::ALPHA_C - LW'(1)) begin
          state_d = kvd_pkg::ST_IDLE;
        end
      end
      kvd_pkg::ST_READ: begin
        // wait here while the output register still holds an untaken result
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_letter_d = kvd_pkg::ASCII_A + 7'(pdiff);
          out_kidx_d   = pos_eff;
          kpos_d       = pos_inc;
          state_d      = kvd_pkg::ST_IDLE;
        end
      end
      default: state_d = kvd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kvd_pkg::ST_IDLE;
      used_q      <= '0;
      fill_q      <= '0;
      kpos_q      <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      fill_q      <= fill_d;
      kpos_q      <= kpos_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_letter_q <= out_letter_d;
    out_kidx_q   <= out_kidx_d;
  end

  // Assertions
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= kvd_pkg::ALPHA_C)
    else $error("alphabet fill count beyond 26");

  a_fill_matches_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == int'(fill_q))
    else $error("fill count disagrees with placed letters");

  a_cipher_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.opcode == kvd_pkg::OP_CIPHER && in_let.hit && used_q[in_let.idx])
    |=> state_q == kvd_pkg::ST_READ)
    else $error("placed ciphertext letter did not start a RAM read");

  a_out_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_letter_q >= 7'h41 && out_letter_q <= 7'h5A
                     && out_kidx_q < KW'(kvd_pkg::MAX_KEY)))
    else $error("result outside A..Z or key index out of range");

endmodule

`default_nettype wire
